// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the SHA-1 engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== rtl/core/sha1_pkg.sv =====
// Types and constants of the SHA-1 engine.
package sha1_pkg;

  localparam int ROUNDS = 80;
  localparam int BLOCK_WORDS = 16;
  localparam int CV_WORDS = 5;

  // Command codes of an input transaction
  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [2:0] LAST_WORD_IDX = 3'd4;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [31:0] INIT_CV [CV_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Controller to datapath commands
  typedef struct packed {
    logic       absorb;    // write message byte, bump count
    logic       pad;       // write 0x80 at fill position
    logic       load_len;  // write bit length into words 14 and 15
    logic       init;      // working vars <- chaining value
    logic       round;     // one compression round
    logic [6:0] rnd;       // round number
    logic       add;       // fold working vars into chaining value, clear block
    logic       shift_out; // move next digest word into place
    logic       restart;   // back to initial chaining value and zero count
  } sha1_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_byte;  // fill position is 63
    logic spill;      // fill position is 56 or more
  } sha1_status_t;

endpackage

// ===== rtl/core/sha1_if.sv =====
// Stream interfaces of the SHA-1 engine: message bytes in, digest words out.
interface sha1_msg_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] message_byte;

  modport source (output valid, command, message_byte, input ready);
  modport sink (input valid, command, message_byte, output ready);
endinterface

interface sha1_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/core/sha1_hash_engine_core.sv =====
// Top level of the SHA-1 engine: controller plus datapath on two streams.
//
// Channel msg carries one transaction per message byte (command absorb) or a
// finish command. Channel digest returns five 32-bit words per finish, most
// significant first, word_index 0 to 4, last_word set on the fifth.
// An absorb transaction is taken in the idle state; the 64th byte of a block
// adds a compression (load, 80 rounds at one round per cycle, add).
// A finish writes the 0x80 pad byte, loads the bit length and compresses
// before the first digest word; when the padding spills into a second block,
// that block is compressed first and the length goes into a further block.
// msg.ready is high only while the engine is idle; one message is processed
// at a time. While the receiver holds digest.ready low, the current word
// stays on the port and nothing else moves. After the fifth word is taken
// the engine is back at the initial chaining value with zero byte count.
// Reset (rst, synchronous) gives the same state.
`include "assert_macros.svh"
module sha1_hash_engine_core (
  input  logic          clk,
  input  logic          rst,
  sha1_msg_if.sink      msg,
  sha1_digest_if.source digest
);
  import sha1_pkg::*;

  sha1_cmd_t    cmd;
  sha1_status_t status;
  logic [2:0]   word_idx;
  logic [31:0]  dp_word;

  sha1_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .msg_valid   (msg.valid),
    .msg_command (msg.command),
    .msg_ready   (msg.ready),
    .out_valid   (digest.valid),
    .out_ready   (digest.ready),
    .word_idx    (word_idx),
    .status      (status),
    .cmd         (cmd)
  );

  sha1_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .message_byte (msg.message_byte),
    .status       (status),
    .digest_word  (dp_word)
  );

  assign digest.digest_word = dp_word;
  assign digest.word_index = word_idx;
  assign digest.last_word = (word_idx == LAST_WORD_IDX);

  // Input and output sides are never open together
  `ASSERT_NEVER(a_no_overlap, clk, rst, msg.ready && digest.valid)
  // Taking the last word returns the engine to idle
  `ASSERT_HOLDS(a_restart, clk, rst,
    (digest.valid && digest.ready && digest.last_word) |=> msg.ready)
  // Words after a non-final transaction follow in order
  `ASSERT_HOLDS(a_word_order, clk, rst,
    (digest.valid && digest.ready && !digest.last_word) |=>
      (digest.valid && digest.word_index == $past(digest.word_index) + 3'd1))
  // Index stays within the digest
  `ASSERT_HOLDS(a_idx_range, clk, rst, digest.valid |-> (digest.word_index <= 3'd4))

endmodule

// ===== rtl/core/sha1_datapath.sv =====
// SHA-1 datapath: block buffer, schedule window, round logic, chaining value.
module sha1_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  sha1_pkg::sha1_cmd_t     cmd,
  input  logic [7:0]              message_byte,
  output sha1_pkg::sha1_status_t  status,
  output logic [31:0]             digest_word
);
  import sha1_pkg::*;

  logic [31:0] cv [CV_WORDS];
  logic [31:0] w [BLOCK_WORDS];
  logic [31:0] a, b, c, d, e;
  logic [63:0] count;

  logic [5:0]  pos;
  logic [7:0]  wr_byte;
  logic [4:0]  lane_sh;
  logic [31:0] lane_mask;
  logic [31:0] lane_data;
  logic [31:0] wt;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] tmp;
  logic [63:0] bit_len;

  assign pos = count[5:0];
  assign status.last_byte = (pos == 6'd63);
  assign status.spill = (pos >= 6'd56);
  assign digest_word = cv[0];
  assign bit_len = {count[60:0], 3'b000};

  // Byte lane selection, big-endian within a word
  assign wr_byte = cmd.pad ? PAD_BYTE : message_byte;
  assign lane_sh = 5'd24 - {pos[1:0], 3'b000};
  assign lane_mask = 32'h0000_00FF << lane_sh;
  assign lane_data = {24'h0, wr_byte} << lane_sh;

  // Schedule word from the rolling window
  always_comb begin
    if (cmd.rnd < 7'd16) begin
      wt = w[0];
    end else begin
      wt = w[13] ^ w[8] ^ w[2] ^ w[0];
      wt = {wt[30:0], wt[31]};
    end
  end

  // Round function and constant by phase
  always_comb begin
    if (cmd.rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K_0;
    end else if (cmd.rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K_1;
    end else if (cmd.rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_2;
    end else begin
      f = b ^ c ^ d;
      k = K_3;
    end
  end

  assign tmp = {a[26:0], a[31:27]} + f + e + k + wt;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CV_WORDS; i++) cv[i] <= INIT_CV[i];
      for (int i = 0; i < BLOCK_WORDS; i++) w[i] <= '0;
      count <= '0;
    end else begin
      // Byte write into the block buffer
      if (cmd.absorb || cmd.pad) begin
        for (int i = 0; i < BLOCK_WORDS; i++) begin
          if (pos[5:2] == 4'(i)) w[i] <= (w[i] & ~lane_mask) | lane_data;
        end
      end
      if (cmd.absorb) count <= count + 64'd1;

      // Message length in bits
      if (cmd.load_len) begin
        w[14] <= bit_len[63:32];
        w[15] <= bit_len[31:0];
      end

      if (cmd.init) begin
        a <= cv[0];
        b <= cv[1];
        c <= cv[2];
        d <= cv[3];
        e <= cv[4];
      end

      // One round: shift the window, rotate the working variables
      if (cmd.round) begin
        for (int i = 0; i < BLOCK_WORDS - 1; i++) w[i] <= w[i + 1];
        w[BLOCK_WORDS - 1] <= wt;
        a <= tmp;
        b <= a;
        c <= {b[1:0], b[31:2]};
        d <= c;
        e <= d;
      end

      if (cmd.add) begin
        cv[0] <= cv[0] + a;
        cv[1] <= cv[1] + b;
        cv[2] <= cv[2] + c;
        cv[3] <= cv[3] + d;
        cv[4] <= cv[4] + e;
        for (int i = 0; i < BLOCK_WORDS; i++) w[i] <= '0;
      end

      // Digest words leave from cv[0]
      if (cmd.shift_out) begin
        for (int i = 0; i < CV_WORDS - 1; i++) cv[i] <= cv[i + 1];
        cv[CV_WORDS - 1] <= cv[0];
      end

      if (cmd.restart) begin
        for (int i = 0; i < CV_WORDS; i++) cv[i] <= INIT_CV[i];
        count <= '0;
      end
    end
  end

endmodule

// ===== rtl/core/sha1_ctrl.sv =====
// SHA-1 controller: absorb, padding, round sequencing and digest output.
module sha1_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    msg_valid,
  input  logic                    msg_command,
  output logic                    msg_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              word_idx,
  input  sha1_pkg::sha1_status_t  status,
  output sha1_pkg::sha1_cmd_t     cmd
);
  import sha1_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_LEN   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state, state_next;
  logic [6:0] rnd, rnd_next;
  logic       fin, fin_next;
  logic       pend_len, pend_len_next;
  logic [2:0] word_idx_next;
  logic       accept;
  logic       out_fire;

  assign msg_ready = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign accept = msg_valid && msg_ready;
  assign out_fire = out_valid && out_ready;

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    rnd_next = rnd;
    fin_next = fin;
    pend_len_next = pend_len;
    word_idx_next = word_idx;
    cmd = '0;
    cmd.rnd = rnd;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (msg_command == CMD_ABSORB) begin
            cmd.absorb = 1'b1;
            fin_next = 1'b0;
            if (status.last_byte) state_next = S_INIT;
          end else begin
            cmd.pad = 1'b1;
            fin_next = 1'b1;
            if (status.spill) begin
              pend_len_next = 1'b1;
              state_next = S_INIT;
            end else begin
              state_next = S_LEN;
            end
          end
        end
      end
      S_LEN: begin
        cmd.load_len = 1'b1;
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.init = 1'b1;
        rnd_next = '0;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (rnd == 7'(ROUNDS - 1)) state_next = S_ADD;
        else rnd_next = rnd + 7'd1;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (pend_len) begin
          pend_len_next = 1'b0;
          state_next = S_LEN;
        end else if (fin) begin
          word_idx_next = '0;
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_fire) begin
          if (word_idx == LAST_WORD_IDX) begin
            cmd.restart = 1'b1;
            fin_next = 1'b0;
            state_next = S_IDLE;
          end else begin
            cmd.shift_out = 1'b1;
            word_idx_next = word_idx + 3'd1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rnd <= '0;
      fin <= 1'b0;
      pend_len <= 1'b0;
      word_idx <= '0;
    end else begin
      state <= state_next;
      rnd <= rnd_next;
      fin <= fin_next;
      pend_len <= pend_len_next;
      word_idx <= word_idx_next;
    end
  end

endmodule
